>>> rtl/tmtw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text mode terminal writer package
// Shared geometry constants, command types and status types for the
// text mode terminal writer.
// ----------------------------------------------------------------------------
package tmtw_pkg;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int CELLS       = ROWS * COLUMNS;

    localparam int COL_W       = $clog2(COLUMNS);
    localparam int ROW_W       = $clog2(ROWS);
    localparam int ADDR_W      = $clog2(CELLS);

    localparam int CHAR_W      = 8;
    localparam int COLOUR_W    = 8;
    localparam int CELL_W      = CHAR_W + COLOUR_W;
    localparam int ACTION_W    = 2;
    localparam int COL_FIELD_W = 7;
    localparam int ROW_FIELD_W = 5;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CHAR_W-1:0]   SPACE_CODE   = 8'd32;
    localparam logic [CHAR_W-1:0]   NEWLINE_CODE = 8'd10;
    localparam logic [COLOUR_W-1:0] RESET_COLOUR = 8'd47;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUT_CHAR = 2'd0,
        ACT_PUT_CELL = 2'd1,
        ACT_CLEAR    = 2'd2,
        ACT_READ     = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        CMD_CHAR,
        CMD_NEWLINE,
        CMD_PUT,
        CMD_CLEAR,
        CMD_READ,
        CMD_NONE
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t              op;
        logic [CHAR_W-1:0]    char_code;
        logic [COLOUR_W-1:0]  colour;
        logic [COL_W-1:0]     col;
        logic [ROW_W-1:0]     row;
    } cmd_t;

    typedef struct packed {
        logic init_busy;
    } back_status_t;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_FILL,
        ST_READ
    } back_state_t;

endpackage

>>> rtl/tmtw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text mode terminal writer front end
// Accepts input transactions, checks positions against the screen size and
// turns each one into a command for the queue.
// ----------------------------------------------------------------------------
module tmtw_front (
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [tmtw_pkg::ACTION_W-1:0]       action,
    input  logic [tmtw_pkg::CHAR_W-1:0]         char_code,
    input  logic [tmtw_pkg::COL_FIELD_W-1:0]    col_pos,
    input  logic [tmtw_pkg::ROW_FIELD_W-1:0]    row_pos,
    input  logic [tmtw_pkg::COLOUR_W-1:0]       cell_colour,
    input  logic                                queue_full,
    input  tmtw_pkg::back_status_t              back_status,
    output logic                                push,
    output tmtw_pkg::cmd_t                      cmd
);
    import tmtw_pkg::*;

    logic in_range;

    assign in_range = (int'(col_pos) < COLUMNS) && (int'(row_pos) < ROWS);
    assign in_stall = queue_full || back_status.init_busy;
    assign push     = in_valid && !in_stall;

    always_comb
    begin
        cmd.char_code = char_code;
        cmd.colour    = cell_colour;
        cmd.col       = COL_W'(col_pos);
        cmd.row       = ROW_W'(row_pos);
        cmd.op        = CMD_NONE;
        unique case (action)
            ACT_PUT_CHAR:
            begin
                cmd.op = (char_code == NEWLINE_CODE) ? CMD_NEWLINE : CMD_CHAR;
            end
            ACT_PUT_CELL:
            begin
                cmd.op = in_range ? CMD_PUT : CMD_NONE;
            end
            ACT_CLEAR:
            begin
                cmd.op = CMD_CLEAR;
            end
            ACT_READ:
            begin
                cmd.op = in_range ? CMD_READ : CMD_NONE;
            end
            default:
            begin
                cmd.op = CMD_NONE;
            end
        endcase
    end

endmodule

>>> rtl/tmtw_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text mode terminal writer command queue
// Short first-in first-out queue of classified commands between the front
// end and the execution back end.
// ----------------------------------------------------------------------------
module tmtw_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tmtw_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            empty,
    output tmtw_pkg::cmd_t  head
);
    import tmtw_pkg::*;

    cmd_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

>>> rtl/tmtw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text mode terminal writer back end
// Executes queued commands against the screen memory, keeps the cursor and
// the top row of the circular screen, and holds the result register.
// ----------------------------------------------------------------------------
module tmtw_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    input  logic [tmtw_pkg::COLOUR_W-1:0]       cfg_data,
    input  logic                                queue_empty,
    input  tmtw_pkg::cmd_t                      head,
    output logic                                pop,
    output tmtw_pkg::back_status_t              back_status,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [tmtw_pkg::CELL_W-1:0]         out_value,
    output logic [tmtw_pkg::ROW_W-1:0]          out_row,
    output logic [tmtw_pkg::COL_W-1:0]          out_col,
    output logic                                out_scrolled
);
    import tmtw_pkg::*;

    back_state_t          state_reg;
    back_state_t          state_next;
    logic [ROW_W-1:0]     cur_row_reg;
    logic [ROW_W-1:0]     cur_row_next;
    logic [COL_W-1:0]     cur_col_reg;
    logic [COL_W-1:0]     cur_col_next;
    logic [ROW_W-1:0]     top_reg;
    logic [ROW_W-1:0]     top_next;
    logic [ADDR_W-1:0]    fill_addr_reg;
    logic [ADDR_W-1:0]    fill_addr_next;
    logic [ADDR_W-1:0]    fill_end_reg;
    logic [ADDR_W-1:0]    fill_end_next;
    logic [COLOUR_W-1:0]  fill_colour_reg;
    logic [COLOUR_W-1:0]  fill_colour_next;
    logic [COLOUR_W-1:0]  text_colour_reg;
    logic [COLOUR_W-1:0]  text_colour_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [CELL_W-1:0]    out_value_reg;
    logic [CELL_W-1:0]    out_value_next;
    logic [ROW_W-1:0]     out_row_reg;
    logic [ROW_W-1:0]     out_row_next;
    logic [COL_W-1:0]     out_col_reg;
    logic [COL_W-1:0]     out_col_next;
    logic                 out_scrolled_reg;
    logic                 out_scrolled_next;

    logic [CELL_W-1:0]    screen_mem [CELLS];
    logic [CELL_W-1:0]    rd_data_reg;

    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [CELL_W-1:0]    mem_wdata;
    logic                 mem_re;

    logic                 out_free;
    logic                 go;
    logic                 fill_done;
    logic                 is_text;
    logic                 wrap;
    logic                 scroll_needed;
    logic                 at_last_col;
    logic                 at_last_row;
    logic [ROW_W-1:0]     row_sel;
    logic [COL_W-1:0]     col_sel;
    logic [ROW_W:0]       phys_sum;
    logic [ROW_W-1:0]     phys_row;
    logic [ADDR_W-1:0]    access_addr;
    logic [ADDR_W-1:0]    top_base;

    assign out_free      = !out_valid_reg || !out_stall;
    assign go            = (state_reg == ST_IDLE) && !queue_empty && out_free;
    assign pop           = go;
    assign fill_done     = (fill_addr_reg == fill_end_reg);
    assign is_text       = (head.op == CMD_CHAR) || (head.op == CMD_NEWLINE);
    assign at_last_col   = (cur_col_reg == COL_W'(COLUMNS - 1));
    assign at_last_row   = (cur_row_reg == ROW_W'(ROWS - 1));
    assign wrap          = (head.op == CMD_NEWLINE) || at_last_col;
    assign scroll_needed = is_text && wrap && at_last_row;

    assign row_sel     = is_text ? cur_row_reg : head.row;
    assign col_sel     = is_text ? cur_col_reg : head.col;
    assign phys_sum    = {1'b0, row_sel} + {1'b0, top_reg};
    assign phys_row    = (phys_sum >= (ROW_W + 1)'(ROWS)) ?
                         ROW_W'(phys_sum - (ROW_W + 1)'(ROWS)) : ROW_W'(phys_sum);
    assign access_addr = ADDR_W'(phys_row) * ADDR_W'(COLUMNS) + ADDR_W'(col_sel);
    assign top_base    = ADDR_W'(top_reg) * ADDR_W'(COLUMNS);

    assign back_status.init_busy = (state_reg == ST_INIT);

    assign out_valid    = out_valid_reg;
    assign out_value    = out_value_reg;
    assign out_row      = out_row_reg;
    assign out_col      = out_col_reg;
    assign out_scrolled = out_scrolled_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT, ST_FILL:
            begin
                if (fill_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (go)
                begin
                    if (head.op == CMD_READ)
                    begin
                        state_next = ST_READ;
                    end
                    else if ((head.op == CMD_CLEAR) || scroll_needed)
                    begin
                        state_next = ST_FILL;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cur_row_next      = cur_row_reg;
        cur_col_next      = cur_col_reg;
        top_next          = top_reg;
        fill_addr_next    = fill_addr_reg;
        fill_end_next     = fill_end_reg;
        fill_colour_next  = fill_colour_reg;
        text_colour_next  = cfg_valid ? cfg_data : text_colour_reg;
        out_valid_next    = out_valid_reg && out_stall;
        out_value_next    = out_value_reg;
        out_row_next      = out_row_reg;
        out_col_next      = out_col_reg;
        out_scrolled_next = out_scrolled_reg;
        mem_we            = 1'b0;
        mem_waddr         = access_addr;
        mem_wdata         = {fill_colour_reg, SPACE_CODE};
        mem_re            = 1'b0;

        unique case (state_reg)
            ST_INIT, ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = fill_addr_reg;
                if (!fill_done)
                begin
                    fill_addr_next = fill_addr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (go)
                begin
                    out_valid_next    = 1'b1;
                    out_value_next    = '0;
                    out_scrolled_next = 1'b0;
                    case (head.op)
                        CMD_CHAR, CMD_NEWLINE:
                        begin
                            if (head.op == CMD_CHAR)
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = {text_colour_reg, head.char_code};
                            end
                            if (wrap)
                            begin
                                cur_col_next = '0;
                                if (at_last_row)
                                begin
                                    top_next          = (top_reg == ROW_W'(ROWS - 1)) ?
                                                        '0 : top_reg + 1'b1;
                                    fill_addr_next    = top_base;
                                    fill_end_next     = top_base + ADDR_W'(COLUMNS - 1);
                                    fill_colour_next  = text_colour_reg;
                                    out_scrolled_next = 1'b1;
                                end
                                else
                                begin
                                    cur_row_next = cur_row_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                cur_col_next = cur_col_reg + 1'b1;
                            end
                        end
                        CMD_PUT:
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {head.colour, head.char_code};
                        end
                        CMD_CLEAR:
                        begin
                            cur_row_next     = '0;
                            cur_col_next     = '0;
                            top_next         = '0;
                            fill_addr_next   = '0;
                            fill_end_next    = ADDR_W'(CELLS - 1);
                            fill_colour_next = text_colour_reg;
                        end
                        CMD_READ:
                        begin
                            mem_re         = 1'b1;
                            out_valid_next = 1'b0;
                        end
                        default:
                        begin
                            out_value_next = '0;
                        end
                    endcase
                    out_row_next = cur_row_next;
                    out_col_next = cur_col_next;
                end
            end
            ST_READ:
            begin
                out_valid_next    = 1'b1;
                out_value_next    = rd_data_reg;
                out_scrolled_next = 1'b0;
                out_row_next      = cur_row_reg;
                out_col_next      = cur_col_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_INIT;
            cur_row_reg     <= '0;
            cur_col_reg     <= '0;
            top_reg         <= '0;
            fill_addr_reg   <= '0;
            fill_end_reg    <= ADDR_W'(CELLS - 1);
            fill_colour_reg <= RESET_COLOUR;
            text_colour_reg <= RESET_COLOUR;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            cur_row_reg     <= cur_row_next;
            cur_col_reg     <= cur_col_next;
            top_reg         <= top_next;
            fill_addr_reg   <= fill_addr_next;
            fill_end_reg    <= fill_end_next;
            fill_colour_reg <= fill_colour_next;
            text_colour_reg <= text_colour_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg    <= out_value_next;
        out_row_reg      <= out_row_next;
        out_col_reg      <= out_col_next;
        out_scrolled_reg <= out_scrolled_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= screen_mem[access_addr];
        end
    end

endmodule

>>> rtl/text_mode_terminal_writer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text mode terminal writer core
// Character console engine: an 80 by 25 screen of 16-bit cells with cursor,
// put-char, put-cell, clear, read and scroll-up.
//
// Each input transaction (action, char_code, col_pos, row_pos, cell_colour)
// returns exactly one output transaction with the cell read, the cursor after
// the command and a scroll flag. The colour register is written through the
// cfg channel, which is always ready.
// Put-char, newline, put-cell and ignored commands are done by the back end
// in state ST_IDLE as they leave the queue, and their result is held in
// the output register. A read needs the extra ST_READ state because the
// screen memory has a registered read port. Clear produces its result when
// it is taken from the queue, then blocks the next command while the memory
// is refilled one cell per cycle. A scroll moves the top row of a circular
// screen and refills the new bottom row, blocking the next command while it
// does so. A two-entry queue lets the input keep taking transactions while
// the back end is busy or the receiver stalls; a stalled result holds in the
// output register until it is taken. After reset the screen memory is filled
// with spaces in colour 47, with in_stall high for that whole pass.
// ----------------------------------------------------------------------------
module text_mode_terminal_writer_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [tmtw_pkg::ACTION_W-1:0]       action,
    input  logic [tmtw_pkg::CHAR_W-1:0]         char_code,
    input  logic [tmtw_pkg::COL_FIELD_W-1:0]    col_pos,
    input  logic [tmtw_pkg::ROW_FIELD_W-1:0]    row_pos,
    input  logic [tmtw_pkg::COLOUR_W-1:0]       cell_colour,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [tmtw_pkg::CELL_W-1:0]         cell_value,
    output logic [tmtw_pkg::ROW_FIELD_W-1:0]    cursor_row,
    output logic [tmtw_pkg::COL_FIELD_W-1:0]    cursor_col,
    output logic                                scrolled,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tmtw_pkg::COLOUR_W-1:0]       cfg_data
);
    import tmtw_pkg::*;

    logic          push;
    cmd_t          push_cmd;
    logic          queue_full;
    logic          queue_empty;
    logic          pop;
    cmd_t          head;
    back_status_t  back_status;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;

    assign cfg_ready  = 1'b1;
    assign cursor_row = ROW_FIELD_W'(out_row);
    assign cursor_col = COL_FIELD_W'(out_col);

    tmtw_front u_front (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .char_code   (char_code),
        .col_pos     (col_pos),
        .row_pos     (row_pos),
        .cell_colour (cell_colour),
        .queue_full  (queue_full),
        .back_status (back_status),
        .push        (push),
        .cmd         (push_cmd)
    );

    tmtw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .pop      (pop),
        .empty    (queue_empty),
        .head     (head)
    );

    tmtw_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .queue_empty  (queue_empty),
        .head         (head),
        .pop          (pop),
        .back_status  (back_status),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_value    (cell_value),
        .out_row      (out_row),
        .out_col      (out_col),
        .out_scrolled (scrolled)
    );

endmodule
